### rtl/core/scbpe_pkg.sv
// Package for the smartcard block protocol engine: codes, constants and state types.
package scbpe_pkg;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_RECV  = 2'd1,
    FN_FAIL  = 2'd2,
    FN_BAD   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_TX   = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_ALIVE  = 2'd0,
    MODE_RESYNC = 2'd1,
    MODE_DEAD   = 2'd2
  } link_mode_t;

  // Block kind, top two bits of the control byte
  localparam logic [1:0] KIND_R = 2'b10;
  localparam logic [1:0] KIND_S = 2'b11;

  localparam logic [7:0] PCB_S_REQ  = 8'hC0;
  localparam logic [7:0] PCB_R_BASE = 8'h80;
  localparam logic [7:0] ERR_EDC    = 8'h01;
  localparam logic [7:0] ERR_OTHER  = 8'h02;
  localparam int unsigned S_RESP_BIT = 5;

  localparam logic [7:0] RETRY_WRAP   = 8'hFF;
  localparam logic [7:0] RETRY_RST    = 8'd3;
  localparam logic [1:0] RESYNC_LIMIT = 2'd3;

  typedef struct packed {
    link_mode_t  mode;
    logic        seq;
    logic        exp_seq;
    logic [7:0]  retry_left;
    logic [1:0]  resync_left;
    logic [7:0]  pend_len;
    logic [15:0] cap_left;
    logic        active;
  } state_t;

endpackage

### rtl/core/smartcard_block_protocol_engine.sv
// Smartcard T=1 block protocol engine: one event in, one block decision out.
// An accepted item goes through the input register, then the result register.
// One item per cycle unless the result stalls; combinational logic closes the state loop.
// in_tready falls only while the input register is full and the result is stalled.
// Reset (rst_n low, synchronous): link alive, counters and sequence bits at reset
// values, no transfer open, max_retries back to 3, both stages empty.
module smartcard_block_protocol_engine (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: max_retries
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // send_length[7:0], rx_capacity[23:8], rx_pcb[31:24],
                                 // rx_len[39:32], checksum_ok[40], zero pad[47:41]
  input  logic [1:0]  in_tuser,  // func[1:0]
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // tx_pcb[7:0], tx_len[15:8], delivered_len[23:16],
                                 // link_status[25:24], zero pad[31:26]
  output logic [1:0]  out_tuser  // status[1:0]
);

  logic        in_vld_r;
  logic [1:0]  in_func_r;
  logic [7:0]  in_slen_r;
  logic [15:0] in_cap_r;
  logic [7:0]  in_pcb_r;
  logic [7:0]  in_rlen_r;
  logic        in_csum_r;

  logic        out_vld_r;
  logic [1:0]  out_status_r;
  logic [7:0]  out_pcb_r;
  logic [7:0]  out_len_r;
  logic [7:0]  out_dlv_r;
  logic [1:0]  out_link_r;

  logic [7:0]  max_retries_r;
  scbpe_pkg::state_t state_r;
  scbpe_pkg::state_t state_nxt;

  logic        advance;
  logic [1:0]  res_status;
  logic [7:0]  res_pcb;
  logic [7:0]  res_len;
  logic [7:0]  res_dlv;
  logic        tx_req;
  logic        fail;
  logic [7:0]  tx_pcb;
  logic [7:0]  tx_len;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_func_r <= in_tuser;
      in_slen_r <= in_tdata[7:0];
      in_cap_r  <= in_tdata[23:8];
      in_pcb_r  <= in_tdata[31:24];
      in_rlen_r <= in_tdata[39:32];
      in_csum_r <= in_tdata[40];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= scbpe_pkg::RETRY_RST;
    end else if (cfg_we) begin
      max_retries_r <= cfg_wdata;
    end
  end

  // Decision logic, written in the order the protocol takes its steps
  always_comb begin
    state_nxt  = state_r;
    res_status = scbpe_pkg::ST_ERR;
    res_pcb    = '0;
    res_len    = '0;
    res_dlv    = '0;
    tx_req     = 1'b0;
    fail       = 1'b0;
    tx_pcb     = '0;
    tx_len     = '0;
    case (in_func_r)
      scbpe_pkg::FN_START: begin
        state_nxt.active = 1'b0;
        if (in_slen_r != 8'd0) begin
          state_nxt.active      = 1'b1;
          state_nxt.pend_len    = in_slen_r;
          state_nxt.cap_left    = in_cap_r;
          state_nxt.retry_left  = max_retries_r;
          state_nxt.resync_left = scbpe_pkg::RESYNC_LIMIT;
          state_nxt.exp_seq     = state_r.seq;
          tx_pcb = {1'b0, state_r.seq, 6'b0};
          tx_len = in_slen_r;
          if (state_r.mode == scbpe_pkg::MODE_DEAD) begin
            state_nxt.seq  = 1'b0;
            state_nxt.mode = scbpe_pkg::MODE_RESYNC;
            tx_pcb = scbpe_pkg::PCB_S_REQ;
            tx_len = '0;
          end
          tx_req = 1'b1;
        end
      end
      scbpe_pkg::FN_FAIL: begin
        fail = 1'b1;
      end
      scbpe_pkg::FN_RECV: begin
        if (state_r.active) begin
          if (!in_csum_r) begin
            tx_pcb = scbpe_pkg::PCB_R_BASE | {3'b0, state_r.seq, 4'b0} | scbpe_pkg::ERR_EDC;
            tx_req = 1'b1;
          end else begin
            case (in_pcb_r[7:6])
              scbpe_pkg::KIND_R: begin
                if (in_pcb_r[4] != state_r.seq) begin
                  tx_pcb = scbpe_pkg::PCB_R_BASE | {3'b0, state_r.seq, 4'b0}
                           | scbpe_pkg::ERR_OTHER;
                end else begin
                  state_nxt.retry_left = max_retries_r;
                  tx_pcb = {1'b0, state_r.seq, 6'b0};
                  tx_len = state_r.pend_len;
                end
                tx_req = 1'b1;
              end
              scbpe_pkg::KIND_S: begin
                if (in_pcb_r[scbpe_pkg::S_RESP_BIT] &&
                    state_r.mode == scbpe_pkg::MODE_RESYNC) begin
                  state_nxt.mode        = scbpe_pkg::MODE_ALIVE;
                  state_nxt.resync_left = scbpe_pkg::RESYNC_LIMIT;
                  state_nxt.retry_left  = max_retries_r;
                  tx_pcb = {1'b0, state_r.seq, 6'b0};
                  tx_len = state_r.pend_len;
                  tx_req = 1'b1;
                end else if (state_r.resync_left == 2'd0) begin
                  fail = 1'b1;
                end else begin
                  // forced resync, then the usual retry check
                  state_nxt.resync_left = state_r.resync_left - 2'd1;
                  state_nxt.seq         = 1'b0;
                  state_nxt.mode        = scbpe_pkg::MODE_RESYNC;
                  tx_pcb = scbpe_pkg::PCB_S_REQ;
                  tx_req = 1'b1;
                end
              end
              default: begin
                if (in_pcb_r[6] != state_r.exp_seq) begin
                  tx_pcb = scbpe_pkg::PCB_R_BASE | {3'b0, state_r.seq, 4'b0}
                           | scbpe_pkg::ERR_OTHER;
                  tx_req = 1'b1;
                end else begin
                  state_nxt.seq = ~state_r.seq;
                  if ({8'd0, in_rlen_r} > state_r.cap_left) begin
                    fail = 1'b1;
                  end else begin
                    state_nxt.active = 1'b0;
                    res_status = scbpe_pkg::ST_DONE;
                    res_dlv    = in_rlen_r;
                  end
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    // retry check before every transmission
    if (tx_req) begin
      if (state_nxt.retry_left == 8'd0) begin
        state_nxt.retry_left = scbpe_pkg::RETRY_WRAP;
        if (state_nxt.resync_left == 2'd0) begin
          fail = 1'b1;
        end else begin
          state_nxt.resync_left = state_nxt.resync_left - 2'd1;
          state_nxt.seq         = 1'b0;
          state_nxt.mode        = scbpe_pkg::MODE_RESYNC;
          tx_pcb = scbpe_pkg::PCB_S_REQ;
          tx_len = '0;
        end
      end
      if (!fail) begin
        state_nxt.retry_left = state_nxt.retry_left - 8'd1;
        res_status = scbpe_pkg::ST_TX;
        res_pcb    = tx_pcb;
        res_len    = tx_len;
      end
    end

    if (fail) begin
      state_nxt.mode   = scbpe_pkg::MODE_DEAD;
      state_nxt.active = 1'b0;
      res_status = scbpe_pkg::ST_ERR;
      res_pcb    = '0;
      res_len    = '0;
      res_dlv    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= scbpe_pkg::MODE_ALIVE;
      state_r.seq         <= 1'b0;
      state_r.exp_seq     <= 1'b0;
      state_r.retry_left  <= '0;
      state_r.resync_left <= scbpe_pkg::RESYNC_LIMIT;
      state_r.pend_len    <= '0;
      state_r.cap_left    <= '0;
      state_r.active      <= 1'b0;
      out_vld_r           <= 1'b0;
    end else begin
      if (advance) begin
        state_r   <= state_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (advance) begin
      out_status_r <= res_status;
      out_pcb_r    <= res_pcb;
      out_len_r    <= res_len;
      out_dlv_r    <= res_dlv;
      out_link_r   <= state_nxt.mode;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_link_r, out_dlv_r, out_len_r, out_pcb_r};

`ifndef SYNTHESIS
  a_hdr_only_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r != scbpe_pkg::ST_TX |-> out_pcb_r == 8'd0 && out_len_r == 8'd0)
    else $error("block header present on a non-transmit result");

  a_dlv_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r != scbpe_pkg::ST_DONE |-> out_dlv_r == 8'd0)
    else $error("delivered length present on a non-done result");

  a_fail_kills_link: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_func_r == scbpe_pkg::FN_FAIL |=>
      state_r.mode == scbpe_pkg::MODE_DEAD && !state_r.active)
    else $error("link failure did not mark the link dead");

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_status == scbpe_pkg::ST_DONE |=> !state_r.active)
    else $error("transfer still open after done");

  a_link_matches: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_link_r == state_r.mode)
    else $error("reported link status differs from link state");
`endif

endmodule
